@@ hdl/rau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Item types, operation and status codes, and the controller to datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_DEN_FIX  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } rau_req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         status;
   } rau_rsp_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_MUL_A,
      CMD_MUL_B,
      CMD_MUL_C,
      CMD_ACC,
      CMD_PREP,
      CMD_DIV_GCD,
      CMD_GCD_STEP,
      CMD_DIV_QN,
      CMD_DIV_QD,
      CMD_SIGN,
      CMD_DIV_ZERO
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       load;
      logic       out_load;
   } rau_ctrl_type;

   typedef struct packed {
      logic div_zero;
      logic y_zero;
      logic div_done;
   } rau_stat_type;

endpackage

@@ hdl/rau_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit serial divider
// Restoring unsigned divider that produces one quotient bit per cycle and
// pulses done when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module rau_div #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic [WORD_BITS-1:0] quot,
   output logic [WORD_BITS-1:0] rem,
   output logic                 done
);

   localparam int W  = WORD_BITS;
   localparam int CW = $clog2(W);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          ge;

   assign trial  = {rem_ff, quo_ff[W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign ge     = ~diff[W];
   assign rem_in = ge ? diff[W-1:0] : trial[W-1:0];
   assign quo_in = {quo_ff[W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quot = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

@@ hdl/rau_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, shared multiplier, Euclid registers, sign fix-up and
// the result register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module rau_dp
   import rau_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  rau_req_type  req_item,
   input  rau_ctrl_type ctrl,
   output rau_stat_type stat,
   output rau_rsp_type  rsp_item
);

   localparam int W = WORD_BITS;

   logic [1:0]   op_ff;
   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [W-1:0] prod_ff, num_ff, den_ff;
   logic [W-1:0] mn_ff, md_ff, x_ff, y_ff, qn_ff;
   logic [W-1:0] rn_ff, rd_ff;
   logic         sn_ff, sd_ff;
   logic [1:0]   st_ff;
   rau_rsp_type  rsp_ff;

   logic [W-1:0] mul_a, mul_b, mul_res;
   logic         div_start, div_done;
   logic [W-1:0] div_dvd, div_dvs, div_quot, div_rem;
   logic [W-1:0] den_fix, rn_t, rd_t, rn_s, rd_s;

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (ctrl.cmd)
         CMD_MUL_A: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         CMD_MUL_B: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         CMD_MUL_C: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;

   always_comb begin
      div_start = 1'b0;
      div_dvd   = x_ff;
      div_dvs   = y_ff;
      case (ctrl.cmd)
         CMD_DIV_GCD: begin
            div_start = 1'b1;
            div_dvd   = x_ff;
            div_dvs   = y_ff;
         end
         CMD_DIV_QN: begin
            div_start = 1'b1;
            div_dvd   = mn_ff;
            div_dvs   = x_ff;
         end
         CMD_DIV_QD: begin
            div_start = 1'b1;
            div_dvd   = md_ff;
            div_dvs   = x_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   rau_div #(
      .WORD_BITS(W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dvd),
      .divisor (div_dvs),
      .quot    (div_quot),
      .rem     (div_rem),
      .done    (div_done)
   );

   assign den_fix = (den_ff == '0) ? W'(1) : den_ff;

   always_comb begin
      rn_t = sn_ff ? (W'(0) - qn_ff) : qn_ff;
      rd_t = sd_ff ? (W'(0) - div_quot) : div_quot;
      rn_s = rd_t[W-1] ? (W'(0) - rn_t) : rn_t;
      rd_s = rd_t[W-1] ? (W'(0) - rd_t) : rd_t;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff <= req_item.req_type;
         an_ff <= W'(req_item.a_num);
         ad_ff <= W'(req_item.a_den);
         bn_ff <= W'(req_item.b_num);
         bd_ff <= W'(req_item.b_den);
         st_ff <= ST_OK;
      end else begin
         case (ctrl.cmd)
            CMD_MUL_A: begin
               prod_ff <= mul_res;
            end
            CMD_MUL_B: begin
               num_ff  <= prod_ff;
               prod_ff <= mul_res;
            end
            CMD_MUL_C: begin
               den_ff  <= prod_ff;
               prod_ff <= mul_res;
            end
            CMD_ACC: begin
               if (op_ff == OP_ADD) begin
                  num_ff <= num_ff + prod_ff;
               end else if (op_ff == OP_SUB) begin
                  num_ff <= num_ff - prod_ff;
               end
            end
            CMD_PREP: begin
               if (den_ff == '0) begin
                  st_ff <= ST_DEN_FIX;
               end
               sn_ff <= num_ff[W-1];
               sd_ff <= den_fix[W-1];
               mn_ff <= num_ff[W-1] ? (W'(0) - num_ff) : num_ff;
               md_ff <= den_fix[W-1] ? (W'(0) - den_fix) : den_fix;
               x_ff  <= num_ff[W-1] ? (W'(0) - num_ff) : num_ff;
               y_ff  <= den_fix[W-1] ? (W'(0) - den_fix) : den_fix;
            end
            CMD_GCD_STEP: begin
               x_ff <= y_ff;
               y_ff <= div_rem;
            end
            CMD_DIV_QD: begin
               qn_ff <= div_quot;
            end
            CMD_SIGN: begin
               rn_ff <= rn_s;
               if (rd_s[W-1] || (rd_s == '0)) begin
                  rd_ff <= W'(1);
                  st_ff <= ST_DEN_FIX;
               end else begin
                  rd_ff <= rd_s;
               end
            end
            CMD_DIV_ZERO: begin
               rn_ff <= '0;
               rd_ff <= W'(1);
               st_ff <= ST_DIV_ZERO;
            end
            default: begin
               st_ff <= st_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_ff.res_num <= 32'($signed(rn_ff));
         rsp_ff.res_den <= 31'(rd_ff);
         rsp_ff.status  <= st_ff;
      end
   end

   assign stat.div_zero = (op_ff == OP_DIV) && (bn_ff == '0);
   assign stat.y_zero   = (y_ff == '0);
   assign stat.div_done = div_done;
   assign rsp_item      = rsp_ff;

endmodule

@@ hdl/rau_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences the multiplies, the Euclid loop, the two reducing divisions and
// the result hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  rau_stat_type stat,
   output rau_ctrl_type ctrl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_MUL_C,
      S_ACC,
      S_PREP,
      S_GCD_TEST,
      S_GCD_WAIT,
      S_GCD_STEP,
      S_QN_WAIT,
      S_QD_WAIT,
      S_SIGN,
      S_DZ,
      S_OUT
   } state_type;

   state_type  state_ff;
   dp_cmd_type cmd_ff;
   logic       stall_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       out_load;

   assign accept   = req_valid & ~stall_ff;
   assign out_load = (state_ff == S_OUT) & (~rsp_valid_ff | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= CMD_NOP;
         stall_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         cmd_ff <= CMD_NOP;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  stall_ff <= 1'b1;
                  state_ff <= S_MUL_A;
                  cmd_ff   <= CMD_MUL_A;
               end
            end
            S_MUL_A: begin
               if (stat.div_zero) begin
                  state_ff <= S_DZ;
                  cmd_ff   <= CMD_DIV_ZERO;
               end else begin
                  state_ff <= S_MUL_B;
                  cmd_ff   <= CMD_MUL_B;
               end
            end
            S_MUL_B: begin
               state_ff <= S_MUL_C;
               cmd_ff   <= CMD_MUL_C;
            end
            S_MUL_C: begin
               state_ff <= S_ACC;
               cmd_ff   <= CMD_ACC;
            end
            S_ACC: begin
               state_ff <= S_PREP;
               cmd_ff   <= CMD_PREP;
            end
            S_PREP: begin
               state_ff <= S_GCD_TEST;
            end
            S_GCD_TEST: begin
               if (stat.y_zero) begin
                  state_ff <= S_QN_WAIT;
                  cmd_ff   <= CMD_DIV_QN;
               end else begin
                  state_ff <= S_GCD_WAIT;
                  cmd_ff   <= CMD_DIV_GCD;
               end
            end
            S_GCD_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_GCD_STEP;
                  cmd_ff   <= CMD_GCD_STEP;
               end
            end
            S_GCD_STEP: begin
               state_ff <= S_GCD_TEST;
            end
            S_QN_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_QD_WAIT;
                  cmd_ff   <= CMD_DIV_QD;
               end
            end
            S_QD_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_SIGN;
                  cmd_ff   <= CMD_SIGN;
               end
            end
            S_SIGN: begin
               state_ff <= S_OUT;
            end
            S_DZ: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign ctrl.cmd      = cmd_ff;
   assign ctrl.load     = accept;
   assign ctrl.out_load = out_load;
   assign req_stall     = stall_ff;
   assign rsp_valid     = rsp_valid_ff;

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and returns the result
// reduced to lowest terms with a positive denominator and a status code.
// ----------------------------------------------------------------------------
// One item is worked at a time. The serial divider, which retires one quotient
// bit per cycle, sets the time an item takes: it serves every Euclid remainder
// step for the unreduced result and then the two divisions by the common
// divisor. A divide by a zero fraction skips the remaining multiplies, the
// Euclid loop and the divisions. A finished result waits in the output register
// while the next item is already accepted.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rau_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rau_rsp_type rsp_item
);

   rau_ctrl_type ctrl;
   rau_stat_type stat;

   rau_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat     (stat),
      .ctrl     (ctrl)
   );

   rau_dp #(
      .WORD_BITS(WORD_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_item(req_item),
      .ctrl    (ctrl),
      .stat    (stat),
      .rsp_item(rsp_item)
   );

endmodule

@@ tb/rau_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit result checker
// Watches both channels of the unit. It works out the reduced fraction and
// status for every accepted request item and compares each accepted result
// item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rau_result_checker
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  rau_req_type req_item,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rau_rsp_type rsp_item,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          div_zero_count,
   output int          den_fix_count
);

   rau_rsp_type expected_fractions[$];
   rau_rsp_type want;

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      return v[31] ? 32'd0 - v : v;
   endfunction

   function automatic rau_rsp_type reduce_fraction(input rau_req_type r);
      logic [31:0] an, ad, bn, bd, num, den, x, y, rem, g, qn, qd, rn, rd;
      rau_rsp_type res;
      an = r.a_num;
      ad = {1'b0, r.a_den};
      bn = r.b_num;
      bd = {1'b0, r.b_den};
      res.status = ST_OK;
      case (r.req_type)
         OP_ADD: begin
            num = an * bd + bn * ad;
            den = ad * bd;
         end
         OP_SUB: begin
            num = an * bd - bn * ad;
            den = ad * bd;
         end
         OP_MUL: begin
            num = an * bn;
            den = ad * bd;
         end
         default: begin
            if (bn == 32'd0) begin
               res.res_num = '0;
               res.res_den = 31'd1;
               res.status  = ST_DIV_ZERO;
               return res;
            end
            num = an * bd;
            den = ad * bn;
         end
      endcase
      if (den == 32'd0) begin
         den = 32'd1;
         res.status = ST_DEN_FIX;
      end
      x = magnitude(num);
      y = magnitude(den);
      while (y != 32'd0) begin
         rem = x % y;
         x = y;
         y = rem;
      end
      g = (x == 32'd0) ? 32'd1 : x;
      qn = magnitude(num) / g;
      qd = magnitude(den) / g;
      rn = num[31] ? 32'd0 - qn : qn;
      rd = den[31] ? 32'd0 - qd : qd;
      if (rd[31]) begin
         rn = 32'd0 - rn;
         rd = 32'd0 - rd;
      end
      if (rd[31] || rd == 32'd0) begin
         rd = 32'd1;
         res.status = ST_DEN_FIX;
      end
      res.res_num = rn;
      res.res_den = rd[30:0];
      return res;
   endfunction

   // Results are retired before new requests are queued, so a stray result
   // can never be matched against an item accepted on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fractions.size() == 0) begin
               $error("unexpected result item %0d/%0d status %0d",
                  rsp_item.res_num, rsp_item.res_den, rsp_item.status);
               fail_count++;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_item.res_num !== want.res_num) begin
                  $error("res_num mismatch: expected %0d, got %0d",
                     want.res_num, rsp_item.res_num);
                  fail_count++;
               end
               if (rsp_item.res_den !== want.res_den) begin
                  $error("res_den mismatch: expected %0d, got %0d",
                     want.res_den, rsp_item.res_den);
                  fail_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                     want.status, rsp_item.status);
                  fail_count++;
               end
               checked_count++;
               if (want.status == ST_DIV_ZERO) div_zero_count++;
               if (want.status == ST_DEN_FIX) den_fix_count++;
            end
         end
         if (req_valid && !req_stall) begin
            expected_fractions.push_back(reduce_fraction(req_item));
         end
         pending_count = expected_fractions.size();
      end
   end

endmodule

@@ tb/tb_rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed fractions covering the sign, wraparound and divide by zero
// corners, then several hundred random items of mixed magnitude, with random
// stall bursts on the result channel, random gaps between request items, one long result hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit
   import rau_pkg::*;
();

   localparam int HOLD_CYCLES    = 4000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 350;
   localparam int CALM_TAIL      = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   rau_req_type req_item;
   logic        rsp_valid;
   logic        rsp_stall;
   rau_rsp_type rsp_item;

   int fail_count;
   int pending_count;
   int checked_count;
   int div_zero_count;
   int den_fix_count;
   int items_sent;
   bit idling;
   bit long_hold_req;

   rational_arithmetic_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   rau_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .div_zero_count (div_zero_count),
      .den_fix_count  (den_fix_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   // The receiver decides at the rising edge and changes stall at the
   // falling edge, so a hold request from the sender takes effect only once a rising edge has sampled it.
   initial begin : receiver
      bit take_hold;
      bit take_burst;
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         take_hold  = long_hold_req && !hold_done;
         take_burst = idling && ($urandom_range(0, 5) == 0);
         @(negedge clock);
         if (take_hold) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (take_burst) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic rau_req_type fraction_pair(input logic [1:0] op,
                                                 input logic [31:0] an,
                                                 input logic [30:0] ad,
                                                 input logic [31:0] bn,
                                                 input logic [30:0] bd);
      rau_req_type r;
      r.req_type = op;
      r.a_num    = an;
      r.a_den    = ad;
      r.b_num    = bn;
      r.b_den    = bd;
      return r;
   endfunction

   function automatic logic [31:0] edge_num();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'd0;
         4: return 32'd1;
         default: return 32'h8000_0001;
      endcase
   endfunction

   function automatic logic [30:0] edge_den();
      case ($urandom_range(0, 3))
         0: return 31'd1;
         1: return 31'h7FFF_FFFF;
         2: return 31'h4000_0000;
         default: return 31'h7FFF_FFFE;
      endcase
   endfunction

   function automatic rau_req_type random_request();
      rau_req_type r;
      int kind;
      kind = $urandom_range(0, 9);
      r.req_type = 2'($urandom_range(0, 3));
      if (kind <= 3) begin
         r.a_num = $urandom;
         r.a_den = 31'($urandom_range(1, 32'h7FFF_FFFF));
         r.b_num = $urandom;
         r.b_den = 31'($urandom_range(1, 32'h7FFF_FFFF));
      end else if (kind <= 6) begin
         r.a_num = 32'($urandom_range(0, 2000)) - 32'd1000;
         r.a_den = 31'($urandom_range(1, 1000));
         r.b_num = 32'($urandom_range(0, 2000)) - 32'd1000;
         r.b_den = 31'($urandom_range(1, 1000));
      end else if (kind == 7) begin
         r.a_num = $urandom;
         r.a_den = 31'd1 << $urandom_range(0, 30);
         r.b_num = $urandom;
         r.b_den = 31'd1 << $urandom_range(0, 30);
      end else if (kind == 8) begin
         r.req_type = OP_DIV;
         r.a_num = $urandom;
         r.a_den = 31'($urandom_range(1, 32'h7FFF_FFFF));
         r.b_num = 32'd0;
         r.b_den = 31'($urandom_range(1, 32'h7FFF_FFFF));
      end else begin
         r.a_num = edge_num();
         r.a_den = edge_den();
         r.b_num = edge_num();
         r.b_den = edge_den();
      end
      return r;
   endfunction

   task automatic send_item(input rau_req_type r);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_item  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      idling        = 1'b1;
      long_hold_req = 1'b0;
      items_sent    = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(fraction_pair(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3));
      send_item(fraction_pair(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2));
      send_item(fraction_pair(OP_MUL, 32'd2, 31'd3, 32'd3, 31'd4));
      send_item(fraction_pair(OP_DIV, 32'd2, 31'd3, 32'd4, 31'd5));
      send_item(fraction_pair(OP_DIV, 32'd7, 31'd9, 32'd0, 31'd5));
      send_item(fraction_pair(OP_DIV, 32'd0, 31'd1, 32'd0, 31'h7FFF_FFFF));
      send_item(fraction_pair(OP_MUL, 32'd3, 31'h1_0000, 32'd5, 31'h1_0000));
      send_item(fraction_pair(OP_ADD, 32'd1, 31'h1_0000, 32'd1, 31'h1_0000));
      send_item(fraction_pair(OP_MUL, 32'd1, 31'h8000, 32'd1, 31'h1_0000));
      send_item(fraction_pair(OP_DIV, 32'd1, 31'd1, 32'h8000_0000, 31'd1));
      send_item(fraction_pair(OP_ADD, 32'h8000_0000, 31'd1, 32'd0, 31'd1));
      send_item(fraction_pair(OP_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1));
      send_item(fraction_pair(OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                              32'h7FFF_FFFF, 31'h7FFF_FFFF));
      send_item(fraction_pair(OP_SUB, 32'h8000_0000, 31'h7FFF_FFFF,
                              32'h7FFF_FFFF, 31'd1));
      send_item(fraction_pair(OP_DIV, 32'd3, 31'd4, 32'hFFFF_FFF7, 31'd8));
      send_item(fraction_pair(OP_MUL, 32'd0, 31'd1, 32'd5, 31'd7));
      send_item(fraction_pair(OP_ADD, 32'hFFFF_FFFF, 31'd1, 32'd1, 31'd1));
      send_item(fraction_pair(OP_DIV, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1));
      send_item(fraction_pair(OP_SUB, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                              32'h8000_0000, 31'h7FFF_FFFF));
      send_item(fraction_pair(OP_DIV, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                              32'h8000_0000, 31'h7FFF_FFFF));
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_TAIL) begin
            idling = 1'b0;
         end else if (i % 25 == 0) begin
            idling = ($urandom_range(0, 2) != 0);
         end
         if (i == 80) long_hold_req = 1'b1;
         if (i == 200) drain_results();
         send_item(random_request());
      end
      drain_results();
      repeat (100) @(negedge clock);

      $display("Run covered %0d items, %0d results checked, %0d divide by zero and",
         items_sent, checked_count, div_zero_count);
      $display("%0d denominator fixups, under random stalls, one long hold-off and drains.",
         den_fix_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/rau_pkg.sv
hdl/rau_div.sv
hdl/rau_dp.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
tb/rau_result_checker.sv
tb/tb_rational_arithmetic_unit.sv
